### rtl/ppls_pkg.sv
// Shared types, constants and helpers of the projection profile line segmenter.
`default_nettype none

package ppls_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   localparam int PIXEL_W = 8;
   localparam int IDX_W   = 10;
   localparam int COUNT_W = 11;
   localparam int SIZE_W  = 13;
   localparam int ADDR_W  = 12;
   localparam int CSR_W   = 2;

   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd200;
   localparam logic [COUNT_W-1:0] SIZE_RESET      = 11'd1024;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 11'd2047;

   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   typedef enum logic {
      KIND_ROW    = 1'b0,
      KIND_COLUMN = 1'b1
   } result_kind_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WIDTH     = 2'd1,
      CSR_HEIGHT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      result_kind_type     kind;
      logic [IDX_W-1:0]    index;
      logic [COUNT_W-1:0]  count;
      logic                line_closed;
      logic [IDX_W-1:0]    line_top;
      logic [COUNT_W-1:0]  line_bottom;
   } result_type;

   typedef struct packed {
      logic               emit;
      logic               mem_en;
      logic               inc;
      logic [ADDR_W-1:0]  addr;
      result_type         res;
   } command_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/projection_profile_line_segmenter_top.sv
// Top level of the projection profile line segmenter.
// The block takes grey pixels in raster order and column readout requests on
// a queue-like input: an item is taken at a clock edge with push high and
// full low. Results leave through a queue-like output: the oldest result sits
// on the rsp_ ports while empty is low and is taken at an edge with pop high.
// Pixels that do not end a row give no result; a row end gives the row's dark
// count and any text line that closed there; a readout returns and clears one
// column count. Settings are written on the csr_ channel, which is always
// ready, while the block is idle; the user must keep to this, the block does
// not enforce it. One item is taken per cycle while full is low. A result
// passes the command queue, back end register and result queue. The column
// count memory does one read and one write per cycle, with the previous write
// forwarded to the next read. After reset, full stays high while the column
// memory is cleared one entry per cycle. When the receiver stops popping, the
// four entry result queue and a two entry command queue fill and full rises.
`default_nettype none

module projection_profile_line_segmenter_top #(
   parameter int MAX_WIDTH  = ppls_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = ppls_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic                          req_type,
   input  wire logic [ppls_pkg::PIXEL_W-1:0]  req_pixel_value,
   input  wire logic [ppls_pkg::IDX_W-1:0]    req_read_column,
   output logic                               empty,
   input  wire logic                          pop,
   output logic                               rsp_result_kind,
   output logic [ppls_pkg::IDX_W-1:0]         rsp_profile_index,
   output logic [ppls_pkg::COUNT_W-1:0]       rsp_dark_count,
   output logic                               rsp_line_closed,
   output logic [ppls_pkg::IDX_W-1:0]         rsp_line_top,
   output logic [ppls_pkg::COUNT_W-1:0]       rsp_line_bottom,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ppls_pkg::CSR_W-1:0]    csr_index,
   input  wire logic [ppls_pkg::COUNT_W-1:0]  csr_data
);

   import ppls_pkg::*;

   logic [PIXEL_W-1:0] threshold_ff;
   logic [COUNT_W-1:0] width_ff;
   logic [COUNT_W-1:0] height_ff;

   logic               item_valid;
   command_type        front_cmd;
   command_type        cmd_head;
   logic               cmd_full, cmd_empty, cmd_pop;
   logic               rsp_full, rsp_push, clearing;
   result_type         rsp_data, rsp_head;

   assign csr_ready  = 1'b1;
   assign full       = cmd_full || clearing;
   assign item_valid = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data[PIXEL_W-1:0];
            CSR_WIDTH:     width_ff     <= csr_data;
            CSR_HEIGHT:    height_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ppls_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .req_type       (req_type),
      .pixel_value    (req_pixel_value),
      .read_column    (req_read_column),
      .dark_threshold (threshold_ff),
      .image_width    (width_ff),
      .image_height   (height_ff),
      .cmd            (front_cmd)
   );

   ppls_fifo #(
      .WIDTH ($bits(command_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_valid),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   ppls_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .clearing  (clearing)
   );

   ppls_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .pop       (pop),
      .empty     (empty),
      .head      (rsp_head)
   );

   assign rsp_result_kind   = rsp_head.kind;
   assign rsp_profile_index = rsp_head.index;
   assign rsp_dark_count    = rsp_head.count;
   assign rsp_line_closed   = rsp_head.line_closed;
   assign rsp_line_top      = rsp_head.line_top;
   assign rsp_line_bottom   = rsp_head.line_bottom;

endmodule

`default_nettype wire

### rtl/ppls_fifo.sv
// Small register queue with full and empty flags decoded from a registered count.
`default_nettype none

module ppls_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/ppls_front.sv
// Front end: classifies items, tracks raster position, row profile and text lines.
`default_nettype none

module ppls_front #(
   parameter int MAX_WIDTH  = ppls_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = ppls_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           item_valid,
   input  wire logic                           req_type,
   input  wire logic [ppls_pkg::PIXEL_W-1:0]   pixel_value,
   input  wire logic [ppls_pkg::IDX_W-1:0]     read_column,
   input  wire logic [ppls_pkg::PIXEL_W-1:0]   dark_threshold,
   input  wire logic [ppls_pkg::COUNT_W-1:0]   image_width,
   input  wire logic [ppls_pkg::COUNT_W-1:0]   image_height,
   output ppls_pkg::command_type               cmd
);

   import ppls_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [CW-1:0]      col_pos_ff, col_pos_in;
   logic [RW-1:0]      row_pos_ff, row_pos_in;
   logic [COUNT_W-1:0] row_cnt_ff, row_cnt_in;
   logic               inside_ff, inside_in;
   logic [RW-1:0]      open_top_ff, open_top_in;

   logic [SIZE_W-1:0]  w_eff, h_eff;
   logic               dark, row_end, last_row;
   logic [COUNT_W-1:0] row_cnt;

   always_comb begin
      if (image_width == '0) begin
         w_eff = SIZE_W'(1);
      end else if (SIZE_W'(image_width) > SIZE_W'(MAX_WIDTH)) begin
         w_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         w_eff = SIZE_W'(image_width);
      end
      if (image_height == '0) begin
         h_eff = SIZE_W'(1);
      end else if (SIZE_W'(image_height) > SIZE_W'(MAX_HEIGHT)) begin
         h_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = SIZE_W'(image_height);
      end

      dark     = (pixel_value <= dark_threshold);
      row_cnt  = dark ? sat_inc(row_cnt_ff) : row_cnt_ff;
      row_end  = (SIZE_W'(col_pos_ff) + SIZE_W'(1)) >= w_eff;
      last_row = (SIZE_W'(row_pos_ff) + SIZE_W'(1)) >= h_eff;

      col_pos_in  = col_pos_ff;
      row_pos_in  = row_pos_ff;
      row_cnt_in  = row_cnt_ff;
      inside_in   = inside_ff;
      open_top_in = open_top_ff;
      cmd         = '0;

      if (req_type == REQ_READ) begin
         cmd.emit      = 1'b1;
         cmd.mem_en    = SIZE_W'(read_column) < SIZE_W'(MAX_WIDTH);
         cmd.addr      = ADDR_W'(read_column);
         cmd.res.kind  = KIND_COLUMN;
         cmd.res.index = read_column;
      end else begin
         cmd.mem_en = 1'b1;
         cmd.inc    = dark;
         cmd.addr   = ADDR_W'(col_pos_ff);
         if (!row_end) begin
            col_pos_in = col_pos_ff + CW'(1);
            row_cnt_in = row_cnt;
         end else begin
            cmd.emit      = 1'b1;
            cmd.res.kind  = KIND_ROW;
            cmd.res.index = IDX_W'(row_pos_ff);
            cmd.res.count = row_cnt;
            if (row_cnt != '0 && !inside_ff) begin
               inside_in   = 1'b1;
               open_top_in = row_pos_ff;
            end else if (row_cnt == '0 && inside_ff) begin
               inside_in             = 1'b0;
               cmd.res.line_closed   = 1'b1;
               cmd.res.line_top      = IDX_W'(open_top_ff);
               cmd.res.line_bottom   = COUNT_W'(row_pos_ff);
            end
            if (last_row) begin
               if (inside_in) begin
                  inside_in           = 1'b0;
                  cmd.res.line_closed = 1'b1;
                  cmd.res.line_top    = IDX_W'(open_top_in);
                  cmd.res.line_bottom = COUNT_W'(h_eff);
               end
               row_pos_in = '0;
            end else begin
               row_pos_in = row_pos_ff + RW'(1);
            end
            col_pos_in = '0;
            row_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         row_cnt_ff  <= '0;
         inside_ff   <= 1'b0;
         open_top_ff <= '0;
      end else if (item_valid) begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         row_cnt_ff  <= row_cnt_in;
         inside_ff   <= inside_in;
         open_top_ff <= open_top_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ppls_back.sv
// Back end: column count memory with read-modify-write, forwarding and reset clearing.
`default_nettype none

module ppls_back #(
   parameter int MAX_WIDTH = ppls_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_empty,
   input  wire ppls_pkg::command_type  cmd_head,
   output logic                        cmd_pop,
   input  wire logic                   rsp_full,
   output logic                        rsp_push,
   output ppls_pkg::result_type        rsp_data,
   output logic                        clearing
);

   import ppls_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [COUNT_W-1:0] mem [MAX_WIDTH];
   logic [COUNT_W-1:0] rdata_ff;
   logic               hit_ff;
   logic [COUNT_W-1:0] hit_data_ff;

   logic               clear_ff;
   logic [CW-1:0]      clear_addr_ff;

   logic               b_valid_ff, b_valid_in;
   command_type        b_cmd_ff;

   logic               b_fire, wr_en;
   logic [CW-1:0]      wr_addr, rd_addr;
   logic [COUNT_W-1:0] wr_data, old_count;

   assign clearing  = clear_ff;
   assign rd_addr   = cmd_head.addr[CW-1:0];
   assign old_count = hit_ff ? hit_data_ff : rdata_ff;
   assign b_fire    = b_valid_ff && (!b_cmd_ff.emit || !rsp_full);
   assign cmd_pop   = !clear_ff && !cmd_empty && (!b_valid_ff || b_fire);
   assign rsp_push  = b_fire && b_cmd_ff.emit;

   always_comb begin
      rsp_data = b_cmd_ff.res;
      if (b_cmd_ff.res.kind == KIND_COLUMN) begin
         rsp_data.count = b_cmd_ff.mem_en ? old_count : '0;
      end
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         wr_addr = b_cmd_ff.addr[CW-1:0];
         if (b_cmd_ff.res.kind == KIND_COLUMN) begin
            wr_en   = b_fire && b_cmd_ff.mem_en;
            wr_data = '0;
         end else begin
            wr_en   = b_fire && b_cmd_ff.inc;
            wr_data = sat_inc(old_count);
         end
      end
      b_valid_in = b_valid_ff;
      if (cmd_pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         b_valid_ff    <= 1'b0;
      end else begin
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + CW'(1);
            if (clear_addr_ff == CW'(MAX_WIDTH - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd_pop) begin
         rdata_ff    <= mem[rd_addr];
         hit_ff      <= wr_en && (wr_addr == rd_addr);
         hit_data_ff <= wr_data;
         b_cmd_ff    <= cmd_head;
      end
   end

endmodule

`default_nettype wire

### sim/ppls_checker.sv
// Checker that predicts and compares the segmenter's row and column profile results.
module ppls_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic                          req_type,
   input  logic [ppls_pkg::PIXEL_W-1:0]  req_pixel_value,
   input  logic [ppls_pkg::IDX_W-1:0]    req_read_column,
   input  logic                          empty,
   input  logic                          pop,
   input  logic                          rsp_result_kind,
   input  logic [ppls_pkg::IDX_W-1:0]    rsp_profile_index,
   input  logic [ppls_pkg::COUNT_W-1:0]  rsp_dark_count,
   input  logic                          rsp_line_closed,
   input  logic [ppls_pkg::IDX_W-1:0]    rsp_line_top,
   input  logic [ppls_pkg::COUNT_W-1:0]  rsp_line_bottom,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [ppls_pkg::CSR_W-1:0]    csr_index,
   input  logic [ppls_pkg::COUNT_W-1:0]  csr_data,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ppls_pkg::*;

   localparam int COLUMNS     = DEFAULT_MAX_WIDTH;
   localparam int ROWS        = DEFAULT_MAX_HEIGHT;
   localparam int COUNT_LIMIT = int'(COUNT_MAX);

   int                 column_ink [COLUMNS];
   int                 row_ink;
   int                 column_at;
   int                 row_at;
   bit                 in_line;
   int                 line_start;
   logic [PIXEL_W-1:0] ink_level;
   logic [COUNT_W-1:0] width_setting;
   logic [COUNT_W-1:0] height_setting;
   result_type         awaited_profiles [$];
   int                 reported;

   function automatic int effective_extent(logic [COUNT_W-1:0] v, int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   task automatic project_item();
      result_type r;
      int         w;
      int         h;
      int         col;
      r = '0;
      if (req_type == REQ_READ) begin
         r.kind  = KIND_COLUMN;
         r.index = req_read_column;
         if (int'(req_read_column) < COLUMNS) begin
            r.count = COUNT_W'(column_ink[req_read_column]);
            column_ink[req_read_column] = 0;
         end
         awaited_profiles = {awaited_profiles, r};
         return;
      end
      w   = effective_extent(width_setting, COLUMNS);
      h   = effective_extent(height_setting, ROWS);
      col = (column_at >= COLUMNS) ? COLUMNS - 1 : column_at;
      if (req_pixel_value <= ink_level) begin
         if (column_ink[col] < COUNT_LIMIT) column_ink[col]++;
         if (row_ink < COUNT_LIMIT) row_ink++;
      end
      if (col + 1 < w) begin
         column_at = col + 1;
         return;
      end
      r.kind  = KIND_ROW;
      r.index = IDX_W'(row_at);
      r.count = COUNT_W'(row_ink);
      if (row_ink != 0 && !in_line) begin
         in_line    = 1'b1;
         line_start = row_at;
      end else if (row_ink == 0 && in_line) begin
         in_line       = 1'b0;
         r.line_closed = 1'b1;
         r.line_top    = IDX_W'(line_start);
         r.line_bottom = COUNT_W'(row_at);
      end
      if (row_at + 1 >= h) begin
         if (in_line) begin
            in_line       = 1'b0;
            r.line_closed = 1'b1;
            r.line_top    = IDX_W'(line_start);
            r.line_bottom = COUNT_W'(h);
         end
         row_at = 0;
      end else begin
         row_at++;
      end
      column_at = 0;
      row_ink   = 0;
      awaited_profiles = {awaited_profiles, r};
   endtask

   task automatic compare_result();
      result_type want;
      result_type got;
      got.kind        = result_kind_type'(rsp_result_kind);
      got.index       = rsp_profile_index;
      got.count       = rsp_dark_count;
      got.line_closed = rsp_line_closed;
      got.line_top    = rsp_line_top;
      got.line_bottom = rsp_line_bottom;
      if (awaited_profiles.size() == 0) begin
         fail_count++;
         if (reported < 10) begin
            reported++;
            $display("unexpected: kind %0d idx %0d cnt %0d closed %0d top %0d bot %0d",
                     got.kind, got.index, got.count, got.line_closed, got.line_top,
                     got.line_bottom);
         end
         return;
      end
      want = awaited_profiles.pop_front();
      if (got.kind !== want.kind || got.index !== want.index || got.count !== want.count ||
          got.line_closed !== want.line_closed || got.line_top !== want.line_top ||
          got.line_bottom !== want.line_bottom) begin
         fail_count++;
         if (reported < 10) begin
            reported++;
            $display("mismatch at %0t", $realtime);
            $display("   expected kind %0d idx %0d cnt %0d closed %0d top %0d bot %0d",
                     want.kind, want.index, want.count, want.line_closed,
                     want.line_top, want.line_bottom);
            $display("   actual   kind %0d idx %0d cnt %0d closed %0d top %0d bot %0d",
                     got.kind, got.index, got.count, got.line_closed, got.line_top,
                     got.line_bottom);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (column_ink[i]) column_ink[i] = 0;
         row_ink        = 0;
         column_at      = 0;
         row_at         = 0;
         in_line        = 1'b0;
         line_start     = 0;
         ink_level      = THRESHOLD_RESET;
         width_setting  = SIZE_RESET;
         height_setting = SIZE_RESET;
         awaited_profiles.delete();
         fail_count     = 0;
         reported       = 0;
      end else begin
         if (pop && !empty) compare_result();
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_THRESHOLD: ink_level = csr_data[PIXEL_W-1:0];
               CSR_WIDTH:     width_setting = csr_data;
               CSR_HEIGHT:    height_setting = csr_data;
               default: ;
            endcase
         end
         if (push && !full) project_item();
      end
      pending = awaited_profiles.size();
   end

endmodule

### sim/tb_projection_profile_line_segmenter_top.sv
// Testbench top that drives pixels, readouts and settings into the line segmenter.
module tb_projection_profile_line_segmenter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ppls_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic                req_type = REQ_PIXEL;
   logic [PIXEL_W-1:0]  req_pixel_value = '0;
   logic [IDX_W-1:0]    req_read_column = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic                rsp_result_kind;
   logic [IDX_W-1:0]    rsp_profile_index;
   logic [COUNT_W-1:0]  rsp_dark_count;
   logic                rsp_line_closed;
   logic [IDX_W-1:0]    rsp_line_top;
   logic [COUNT_W-1:0]  rsp_line_bottom;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_index = CSR_THRESHOLD;
   logic [COUNT_W-1:0]  csr_data = '0;
   int                  fail_count;
   int                  pending;

   logic                calm = 1'b0;
   logic                hold_req = 1'b0;
   bit                  hold_taken;
   int                  stall_left;
   int                  cycles;

   projection_profile_line_segmenter_top uut (.*);

   ppls_checker profile_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** projection_profile_line_segmenter_top: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         stall_left = 300;
      end
      if (stall_left > 0) begin
         stall_left--;
         pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   task automatic put_item(req_kind_type kind, logic [PIXEL_W-1:0] level,
                           logic [IDX_W-1:0] column);
      if (!calm && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      push            <= 1'b1;
      req_type        <= kind;
      req_pixel_value <= level;
      req_read_column <= column;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic put_pixel(int level);
      put_item(REQ_PIXEL, PIXEL_W'(level), IDX_W'($urandom_range(0, 1023)));
   endtask

   task automatic put_read(int column);
      put_item(REQ_READ, PIXEL_W'($urandom_range(0, 255)), IDX_W'(column));
   endtask

   task automatic settle();
      push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(int thr, int w, int h);
      csr_index_type regs [3];
      int            vals [3];
      regs = '{CSR_THRESHOLD, CSR_WIDTH, CSR_HEIGHT};
      vals = '{thr, w, h};
      settle();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= COUNT_W'(vals[i]);
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic int shade(int thr, bit dark);
      if (dark) return $urandom_range(0, thr);
      if (thr >= 255) return $urandom_range(0, 255);
      return $urandom_range(thr + 1, 255);
   endfunction

   initial begin
      int random_items;
      int thr;
      int w;
      int h;
      int ew;
      int eh;
      int rows;
      int mode;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      put_read(0);
      put_read(1023);
      put_pixel(0);
      put_pixel(200);
      put_pixel(201);
      put_pixel(255);
      put_read(1);
      put_read(1);
      // The width drops below the current column, so the next pixel ends the row.
      configure(200, 2, 1024);
      put_pixel(255);
      configure(0, 2, 2);
      put_pixel(0);
      put_pixel(1);
      put_pixel(255);
      put_pixel(255);
      put_pixel(0);
      put_pixel(0);
      configure(0, 1, 3);
      put_pixel(0);
      put_pixel(255);
      put_pixel(0);
      put_read(0);
      put_read(1);

      configure(255, 2047, 1);
      repeat (1024) put_pixel($urandom_range(0, 255));
      put_read(0);
      put_read(1023);

      // The receiver holds off while one-pixel rows keep coming, so the block fills up.
      configure(200, 1, 16);
      hold_req <= 1'b1;
      repeat (40) put_pixel($urandom_range(0, 255));

      random_items = 0;
      while (random_items < 420) begin
         calm <= (random_items > 340) || ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0:       thr = 0;
            1:       thr = 255;
            default: thr = $urandom_range(0, 255);
         endcase
         w = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 16);
         h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 12);
         configure(thr, w, h);
         ew = (w == 0) ? 1 : w;
         eh = (h == 0) ? 1 : h;
         rows = eh * $urandom_range(1, 2);
         for (int r = 0; r < rows; r++) begin
            mode = $urandom_range(0, 2);
            for (int c = 0; c < ew; c++) begin
               if ($urandom_range(0, 11) == 0) begin
                  put_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, ew - 1));
                  random_items++;
               end
               case (mode)
                  0:       put_pixel(shade(thr, 1'b0));
                  1:       put_pixel(shade(thr, $urandom_range(0, 1)));
                  default: put_pixel($urandom_range(0, 255));
               endcase
               random_items++;
            end
         end
         repeat ($urandom_range(0, ew - 1)) begin
            put_pixel($urandom_range(0, 255));
            random_items++;
         end
         if ($urandom_range(0, 1) == 1) begin
            for (int c = 0; c < ew; c++) begin
               put_read(c);
               random_items++;
            end
         end
      end

      calm <= 1'b1;
      settle();
      if (fail_count == 0) begin
         $display("** projection_profile_line_segmenter_top: PASSED **");
      end else begin
         $display("** projection_profile_line_segmenter_top: FAILED **");
      end
      $finish;
   end

endmodule
